[src/bvpg_pkg.sv]
// Package for the bitplane video pixel generator: modes, register indexes,
// configuration struct, geometry constants and the intensity level table.
// Depends on nothing; every module of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package bvpg_pkg;

  // Display geometry.
  localparam int unsigned Columns      = 48;
  localparam int unsigned VisibleLines = 256;

  // Memory map and frame buffer layout.
  localparam logic [15:0] PageBase0    = 16'h1000;
  localparam logic [15:0] PageBase1    = 16'h9000;
  localparam logic [15:0] PlaneOffset  = 16'h4000;
  localparam logic [8:0]  WidthBorder  = 9'd417;
  localparam logic [8:0]  WidthPlain   = 9'd384;
  localparam logic [8:0]  XOffBorder   = 9'd21;
  localparam logic [8:0]  YOffBorder   = 9'd10;

  // Item modes.
  typedef enum logic [1:0] {
    ModeAddr     = 2'd0,
    ModePixel    = 2'd1,
    ModeFrameEnd = 2'd2,
    ModeUnused   = 2'd3
  } mode_e;

  // Configuration register indexes.
  localparam logic [3:0] CfgPalette0     = 4'd0;
  localparam logic [3:0] CfgPalette1     = 4'd1;
  localparam logic [3:0] CfgPalette2     = 4'd2;
  localparam logic [3:0] CfgPalette3     = 4'd3;
  localparam logic [3:0] CfgColourEnable = 4'd4;
  localparam logic [3:0] CfgBorder       = 4'd5;
  localparam logic [3:0] CfgPage         = 4'd6;
  localparam logic [3:0] CfgScroll       = 4'd7;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic [3:0][7:0] palette;
    logic            colour_enable;
    logic            border_visible;
    logic            display_page;
    logic [7:0]      vertical_scroll;
  } cfg_t;

  // Intensity levels for a two-bit channel code.
  function automatic logic [7:0] level_of(input logic [1:0] code);
    logic [7:0] lvl;
    unique case (code)
      2'd0: lvl = 8'd0;
      2'd1: lvl = 8'd90;
      2'd2: lvl = 8'd180;
      2'd3: lvl = 8'd255;
      default: lvl = 8'd0;
    endcase
    return lvl;
  endfunction

endpackage

`default_nettype wire

[src/bitplane_video_pixel_generator.sv]
// Top level of the bitplane video pixel generator: input register, result
// sequencer and the glue to the register file and datapath modules.
// Depends on bvpg_pkg, bvpg_cfg_regs, bvpg_column_calc, bvpg_colour_decode.
//
// Usage: input words arrive on in_valid_i/in_ready_o with a mode and the
// column fields; result words leave on out_valid_o/out_ready_i. Registers
// are written through cfg_valid_i/cfg_index_i/cfg_data_i; cfg_ready_o is
// always high and writes are meant only while the block is idle.
// An accepted word is captured in the input register and moves on into
// the result register once that is free; its results are offered from there.
// An address request gives one result word; column data gives eight pixel
// words, one per cycle while the receiver is ready, pixel 0 first, with
// last_o on the eighth. Frame end and unused modes, and words outside
// the visible area, give no result and leave the input register without
// waiting for the result register. The next input word is accepted while
// results are still being sent. A receiver stall holds the current result
// word unchanged and, once the input register holds a word that gives a
// result, drops in_ready_o. Reset empties both registers, restores the
// palette to 0xFF and clears the other registers and the latched scroll.
`timescale 1ns / 1ps
`default_nettype none

module bitplane_video_pixel_generator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  // Input channel.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  scan_line_i,
  input  wire logic [5:0]  column_index_i,
  input  wire logic [7:0]  plane0_byte_i,
  input  wire logic [7:0]  plane1_byte_i,
  // Result channel.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      plane0_address_o,
  output logic [15:0]      plane1_address_o,
  output logic [16:0]      pixel_index_o,
  output logic [7:0]       red_level_o,
  output logic [7:0]       green_level_o,
  output logic [7:0]       blue_level_o,
  output logic             last_o
);

  bvpg_pkg::cfg_t  cfg;
  logic [7:0]      scroll_latched;

  // Input register.
  logic            in_valid_q, in_valid_d;
  bvpg_pkg::mode_e mode_q;
  logic [7:0]      line_q;
  logic [5:0]      col_q;
  logic [7:0]      p0_q, p1_q;

  // Result register.
  logic            out_valid_q, out_valid_d;
  logic            is_pix_q;
  logic [2:0]      cnt_q, cnt_d;
  logic [7:0]      op0_q, op1_q;
  logic [16:0]     row_base_q;
  logic [15:0]     addr_q;

  logic            visible;
  logic [15:0]     addr_calc;
  logic [16:0]     row_base_calc;
  logic            gives_result;
  logic            frame_end;
  logic            out_last;
  logic            out_take;
  logic            s2_free;
  logic            s1_pop;
  logic            in_accept;
  logic [1:0]      colour_index;
  logic [7:0]      red, green, blue;

  assign cfg_ready_o = 1'b1;

  bvpg_cfg_regs u_cfg_regs (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .frame_end_i      (frame_end),
    .cfg_o            (cfg),
    .scroll_latched_o (scroll_latched)
  );

  bvpg_column_calc u_column_calc (
    .cfg_i            (cfg),
    .scroll_latched_i (scroll_latched),
    .scan_line_i      (line_q),
    .column_index_i   (col_q),
    .visible_o        (visible),
    .plane0_address_o (addr_calc),
    .row_base_o       (row_base_calc)
  );

  // Handshake control between the two registers.
  assign gives_result = visible &&
                        ((mode_q == bvpg_pkg::ModeAddr) || (mode_q == bvpg_pkg::ModePixel));
  assign out_last     = !is_pix_q || (cnt_q == 3'd7);
  assign out_take     = out_valid_q && out_ready_i;
  assign s2_free      = !out_valid_q || (out_ready_i && out_last);
  assign s1_pop       = in_valid_q && (!gives_result || s2_free);
  assign frame_end    = s1_pop && (mode_q == bvpg_pkg::ModeFrameEnd);
  assign in_ready_o   = !in_valid_q || s1_pop;
  assign in_accept    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (s1_pop) begin
      in_valid_d = 1'b0;
    end
  end

  // Result register valid and pixel counter.
  always_comb begin
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    if (s1_pop && gives_result) begin
      out_valid_d = 1'b1;
      cnt_d       = 3'd0;
    end else if (out_take) begin
      if (out_last) begin
        out_valid_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= 3'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= bvpg_pkg::mode_e'(mode_i);
      line_q <= scan_line_i;
      col_q  <= column_index_i;
      p0_q   <= plane0_byte_i;
      p1_q   <= plane1_byte_i;
    end
    if (s1_pop && gives_result) begin
      is_pix_q   <= (mode_q == bvpg_pkg::ModePixel);
      op0_q      <= p0_q;
      op1_q      <= p1_q;
      row_base_q <= row_base_calc;
      addr_q     <= addr_calc;
    end
  end

  // Pixel colour of the current bit position.
  assign colour_index = {op1_q[cnt_q], op0_q[cnt_q]};

  bvpg_colour_decode u_colour_decode (
    .cfg_i          (cfg),
    .colour_index_i (colour_index),
    .red_o          (red),
    .green_o        (green),
    .blue_o         (blue)
  );

  // Result word fields; the fields of the other mode read as zero.
  assign out_valid_o      = out_valid_q;
  assign plane0_address_o = is_pix_q ? 16'd0 : addr_q;
  assign plane1_address_o = is_pix_q ? 16'd0 : (addr_q + bvpg_pkg::PlaneOffset);
  assign pixel_index_o    = is_pix_q ? (row_base_q + {14'd0, cnt_q}) : 17'd0;
  assign red_level_o      = is_pix_q ? red : 8'd0;
  assign green_level_o    = is_pix_q ? green : 8'd0;
  assign blue_level_o     = is_pix_q ? blue : 8'd0;
  assign last_o           = out_last;

endmodule

`default_nettype wire

[src/bvpg_cfg_regs.sv]
// Configuration register file and the frame-end scroll latch.
// Depends on bvpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bvpg_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  input  wire logic [3:0]    cfg_index_i,
  input  wire logic [7:0]    cfg_data_i,
  input  wire logic          frame_end_i,
  output bvpg_pkg::cfg_t     cfg_o,
  output logic [7:0]         scroll_latched_o
);

  bvpg_pkg::cfg_t cfg_q, cfg_d;
  logic [7:0]     scroll_q, scroll_d;

  // Register writes; an index past the list leaves everything as it is.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bvpg_pkg::CfgPalette0:     cfg_d.palette[0] = cfg_data_i;
        bvpg_pkg::CfgPalette1:     cfg_d.palette[1] = cfg_data_i;
        bvpg_pkg::CfgPalette2:     cfg_d.palette[2] = cfg_data_i;
        bvpg_pkg::CfgPalette3:     cfg_d.palette[3] = cfg_data_i;
        bvpg_pkg::CfgColourEnable: cfg_d.colour_enable = cfg_data_i[0];
        bvpg_pkg::CfgBorder:       cfg_d.border_visible = cfg_data_i[0];
        bvpg_pkg::CfgPage:         cfg_d.display_page = cfg_data_i[0];
        bvpg_pkg::CfgScroll:       cfg_d.vertical_scroll = cfg_data_i;
        default: ;
      endcase
    end
  end

  // The scroll value takes effect only at frame end.
  assign scroll_d = frame_end_i ? cfg_q.vertical_scroll : scroll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.palette         <= {4{8'hFF}};
      cfg_q.colour_enable   <= 1'b0;
      cfg_q.border_visible  <= 1'b0;
      cfg_q.display_page    <= 1'b0;
      cfg_q.vertical_scroll <= 8'd0;
      scroll_q              <= 8'd0;
    end else begin
      cfg_q    <= cfg_d;
      scroll_q <= scroll_d;
    end
  end

  assign cfg_o            = cfg_q;
  assign scroll_latched_o = scroll_q;

endmodule

`default_nettype wire

[src/bvpg_column_calc.sv]
// Per-column arithmetic: visibility check, plane 0 byte address and the
// frame buffer index of the column's first pixel. Depends on bvpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bvpg_column_calc (
  input  wire bvpg_pkg::cfg_t cfg_i,
  input  wire logic [7:0]    scroll_latched_i,
  input  wire logic [7:0]    scan_line_i,
  input  wire logic [5:0]    column_index_i,
  output logic               visible_o,
  output logic [15:0]        plane0_address_o,
  output logic [16:0]        row_base_o
);

  logic [15:0] base;
  logic [7:0]  line_scrolled;
  logic [8:0]  width;
  logic [8:0]  xoff;
  logic [8:0]  line_off;
  logic [17:0] row_product;
  logic [17:0] row_sum;

  // Items outside the visible area give no result.
  assign visible_o = ({1'b0, scan_line_i} < 9'(bvpg_pkg::VisibleLines)) &&
                     ({1'b0, column_index_i} < 7'(bvpg_pkg::Columns));

  // Address: page base, scrolled line, 256 bytes per column.
  assign base          = cfg_i.display_page ? bvpg_pkg::PageBase1 : bvpg_pkg::PageBase0;
  assign line_scrolled = scan_line_i + scroll_latched_i;
  assign plane0_address_o = base + {8'd0, line_scrolled} + {2'd0, column_index_i, 8'd0};

  // Frame buffer position of pixel 0 of this column.
  assign width    = cfg_i.border_visible ? bvpg_pkg::WidthBorder : bvpg_pkg::WidthPlain;
  assign xoff     = cfg_i.border_visible ? bvpg_pkg::XOffBorder : 9'd0;
  assign line_off = {1'b0, scan_line_i} + (cfg_i.border_visible ? bvpg_pkg::YOffBorder : 9'd0);
  assign row_product = line_off * width;
  assign row_sum     = row_product + {9'd0, column_index_i, 3'd0} + {9'd0, xoff};
  assign row_base_o  = row_sum[16:0];

endmodule

`default_nettype wire

[src/bvpg_colour_decode.sv]
// Palette lookup and channel decoding of a two-bit colour index.
// Depends on bvpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bvpg_colour_decode (
  input  wire bvpg_pkg::cfg_t cfg_i,
  input  wire logic [1:0]    colour_index_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o
);

  logic [7:0] pal;

  // The stored palette byte is inverted before decoding.
  assign pal = ~cfg_i.palette[colour_index_i];

  // Mono uses the low two bits on all channels; colour uses the upper six.
  always_comb begin
    if (cfg_i.colour_enable) begin
      red_o   = bvpg_pkg::level_of(pal[3:2]);
      green_o = bvpg_pkg::level_of(pal[5:4]);
      blue_o  = bvpg_pkg::level_of(pal[7:6]);
    end else begin
      red_o   = bvpg_pkg::level_of(pal[1:0]);
      green_o = red_o;
      blue_o  = red_o;
    end
  end

endmodule

`default_nettype wire

[tb/tb_bitplane_video_pixel_generator.sv]
// Self-checking testbench for the bitplane video pixel generator: a directed table,
// then random words of every mode over several register settings, with stalls.
// Depends on bvpg_pkg and bitplane_video_pixel_generator.
`timescale 1ns / 1ps

module tb_bitplane_video_pixel_generator;

  localparam int unsigned WordsPerPhase  = 45;
  localparam int unsigned NumPhases      = 6;
  localparam int unsigned MaxGap         = 18;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned StallLimit     = 4000;
  localparam int unsigned NumDirected    = 14;
  localparam logic [3:0]  CfgFirstUnused = bvpg_pkg::CfgScroll + 4'd1;
  localparam logic [3:0][7:0] LevelTab   = {8'd255, 8'd180, 8'd90, 8'd0};

  // One result word as it leaves the block.
  typedef struct packed {
    logic [15:0] plane0_address;
    logic [15:0] plane1_address;
    logic [16:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } video_word_t;

  // One row of the directed table; typed rows carry their addresses.
  typedef struct {
    bvpg_pkg::mode_e mode;
    logic [7:0]      line;
    logic [5:0]      col;
    logic [7:0]      p0;
    logic [7:0]      p1;
    bit              typed;
    logic [15:0]     a0;
    logic [15:0]     a1;
  } stim_row_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i    = bvpg_pkg::CfgPalette0;
  logic [7:0]  cfg_data_i     = 8'h00;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i         = bvpg_pkg::ModeAddr;
  logic [7:0]  scan_line_i    = 8'h00;
  logic [5:0]  column_index_i = 6'h00;
  logic [7:0]  plane0_byte_i  = 8'h00;
  logic [7:0]  plane1_byte_i  = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [15:0] plane0_address_o;
  logic [15:0] plane1_address_o;
  logic [16:0] pixel_index_o;
  logic [7:0]  red_level_o;
  logic [7:0]  green_level_o;
  logic [7:0]  blue_level_o;
  logic        last_o;

  // Shadow copy of the registers and the latched scroll.
  logic [3:0][7:0] palette_shadow;
  logic            colour_shadow;
  logic            border_shadow;
  logic            page_shadow;
  logic [7:0]      scroll_shadow;
  logic [7:0]      scroll_latched_shadow;

  video_word_t video_words_q[$];
  int unsigned mismatches    = 0;
  int unsigned words_checked = 0;
  int unsigned words_sent    = 0;
  int unsigned idle_cycles   = 0;
  bit          tx_quiet      = 1'b0;
  bit          rx_quiet      = 1'b0;

  stim_row_t directed_rows [NumDirected] = '{
    '{bvpg_pkg::ModeAddr,     8'd0,   6'd0,  8'h00, 8'h00, 1'b1, 16'h1000, 16'h5000},
    '{bvpg_pkg::ModeAddr,     8'd255, 6'd47, 8'hFF, 8'hFF, 1'b1, 16'h3FFF, 16'h7FFF},
    '{bvpg_pkg::ModeAddr,     8'd128, 6'd1,  8'h00, 8'h00, 1'b1, 16'h1180, 16'h5180},
    '{bvpg_pkg::ModePixel,    8'd0,   6'd0,  8'h00, 8'h00, 1'b0, 16'h0000, 16'h0000},
    '{bvpg_pkg::ModePixel,    8'd255, 6'd47, 8'hFF, 8'hFF, 1'b0, 16'h0000, 16'h0000},
    '{bvpg_pkg::ModePixel,    8'd17,  6'd5,  8'hA5, 8'h3C, 1'b0, 16'h0000, 16'h0000},
    '{bvpg_pkg::ModePixel,    8'd200, 6'd32, 8'h0F, 8'hF0, 1'b0, 16'h0000, 16'h0000},
    '{bvpg_pkg::ModeUnused,   8'd12,  6'd3,  8'h55, 8'hAA, 1'b0, 16'h0000, 16'h0000},
    '{bvpg_pkg::ModeAddr,     8'd0,   6'd48, 8'h00, 8'h00, 1'b0, 16'h0000, 16'h0000},
    '{bvpg_pkg::ModePixel,    8'd99,  6'd63, 8'hFF, 8'h00, 1'b0, 16'h0000, 16'h0000},
    '{bvpg_pkg::ModeFrameEnd, 8'd255, 6'd63, 8'hFF, 8'hFF, 1'b0, 16'h0000, 16'h0000},
    '{bvpg_pkg::ModeAddr,     8'd255, 6'd63, 8'h00, 8'h00, 1'b0, 16'h0000, 16'h0000},
    '{bvpg_pkg::ModePixel,    8'd1,   6'd47, 8'hAA, 8'h55, 1'b0, 16'h0000, 16'h0000},
    '{bvpg_pkg::ModeAddr,     8'd77,  6'd31, 8'h00, 8'h00, 1'b0, 16'h0000, 16'h0000}
  };

  bitplane_video_pixel_generator dut (.*);

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Register write as the block sees it; unused indexes change nothing.
  function automatic void apply_reg(input logic [3:0] idx, input logic [7:0] data);
    case (idx)
      bvpg_pkg::CfgPalette0, bvpg_pkg::CfgPalette1,
      bvpg_pkg::CfgPalette2, bvpg_pkg::CfgPalette3: palette_shadow[idx[1:0]] = data;
      bvpg_pkg::CfgColourEnable: colour_shadow = data[0];
      bvpg_pkg::CfgBorder:       border_shadow = data[0];
      bvpg_pkg::CfgPage:         page_shadow   = data[0];
      bvpg_pkg::CfgScroll:       scroll_shadow = data;
      default: ;
    endcase
  endfunction

  // Work out the result words that one accepted input word causes.
  function automatic void predict_video_words(input bvpg_pkg::mode_e mode,
                                              input logic [7:0] line,
                                              input logic [5:0] col, input logic [7:0] p0,
                                              input logic [7:0] p1);
    video_word_t w;
    logic [7:0]  scrolled;
    logic [7:0]  inv;
    logic [1:0]  ci;
    int unsigned width;
    int unsigned xoff;
    int unsigned yoff;
    int unsigned row_start;
    w = '0;
    case (mode)
      bvpg_pkg::ModeFrameEnd: scroll_latched_shadow = scroll_shadow;
      bvpg_pkg::ModeAddr: begin
        if (col < bvpg_pkg::Columns) begin
          scrolled = line + scroll_latched_shadow;
          w.plane0_address = (page_shadow ? bvpg_pkg::PageBase1 : bvpg_pkg::PageBase0)
                             + {8'h00, scrolled} + {2'b00, col, 8'h00};
          w.plane1_address = w.plane0_address + bvpg_pkg::PlaneOffset;
          w.last = 1'b1;
          video_words_q.push_back(w);
        end
      end
      bvpg_pkg::ModePixel: begin
        if (col < bvpg_pkg::Columns) begin
          width = border_shadow ? bvpg_pkg::WidthBorder : bvpg_pkg::WidthPlain;
          xoff  = border_shadow ? bvpg_pkg::XOffBorder : 0;
          yoff  = border_shadow ? bvpg_pkg::YOffBorder : 0;
          row_start = (int'(line) + yoff) * width + int'(col) * 8 + xoff;
          for (int pt = 0; pt < 8; pt++) begin
            ci  = {p1[pt], p0[pt]};
            inv = ~palette_shadow[ci];
            w.pixel_index = 17'(row_start + pt);
            if (colour_shadow) begin
              w.red   = LevelTab[inv[3:2]];
              w.green = LevelTab[inv[5:4]];
              w.blue  = LevelTab[inv[7:6]];
            end else begin
              w.red   = LevelTab[inv[1:0]];
              w.green = w.red;
              w.blue  = w.red;
            end
            w.last = (pt == 7);
            video_words_q.push_back(w);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Drive one register write and hold it until taken.
  task automatic write_reg(input logic [3:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
  endtask

  // Write every register, plus one index past the list.
  task automatic program_display(input logic [3:0][7:0] pal, input logic colour,
                                 input logic border, input logic page,
                                 input logic [7:0] scroll);
    for (int i = 0; i < 4; i++) write_reg(bvpg_pkg::CfgPalette0 + 4'(i), pal[i]);
    write_reg(bvpg_pkg::CfgColourEnable, {7'd0, colour});
    write_reg(bvpg_pkg::CfgBorder, {7'd0, border});
    write_reg(bvpg_pkg::CfgPage, {7'd0, page});
    write_reg(bvpg_pkg::CfgScroll, scroll);
    write_reg(4'($urandom_range(CfgFirstUnused, 15)), 8'($urandom));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Send one input word after a random gap; typed words skip the predictor.
  task automatic send_word(input bvpg_pkg::mode_e mode, input logic [7:0] line,
                           input logic [5:0] col,
                           input logic [7:0] p0, input logic [7:0] p1, input bit typed,
                           input video_word_t typed_word);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MaxGap);
    repeat (gap) @(negedge clk_i) in_valid_i <= 1'b0;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    scan_line_i    <= line;
    column_index_i <= col;
    plane0_byte_i  <= p0;
    plane1_byte_i  <= p1;
    do @(posedge clk_i); while (!in_ready_o);
    if (typed) video_words_q.push_back(typed_word);
    else predict_video_words(mode, line, col, p0, p1);
    words_sent++;
  endtask

  // Lower valid, wait for the last result, then let the block settle.
  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (video_words_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Result side: a random stall before each word.
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, MaxGap);
      repeat (stall) @(negedge clk_i) out_ready_i <= 1'b0;
      @(negedge clk_i) out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    video_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (video_words_q.size() == 0) begin
        report_mismatch("unexpected result word, pixel_index", pixel_index_o, 0);
      end else begin
        want = video_words_q.pop_front();
        check_field("plane0_address", plane0_address_o, want.plane0_address);
        check_field("plane1_address", plane1_address_o, want.plane1_address);
        check_field("pixel_index", pixel_index_o, want.pixel_index);
        check_field("red_level", red_level_o, want.red);
        check_field("green_level", green_level_o, want.green);
        check_field("blue_level", blue_level_o, want.blue);
        check_field("last", last_o, want.last);
        words_checked++;
      end
    end
  end

  // Watchdog: end the run if no handshake happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Watchdog: no handshake for %0d cycles, %0d words still expected",
                 idle_cycles, video_words_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin : stimulus
    video_word_t     tw;
    logic [3:0][7:0] pal;
    int unsigned     counted;
    int unsigned     pick;
    int unsigned     item;
    bvpg_pkg::mode_e mode;
    logic [5:0]      col;
    palette_shadow        = {4{8'hFF}};
    colour_shadow         = 1'b0;
    border_shadow         = 1'b0;
    page_shadow           = 1'b0;
    scroll_shadow         = 8'h00;
    scroll_latched_shadow = 8'h00;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed table on the reset settings.
    foreach (directed_rows[i]) begin
      tw = '0;
      tw.plane0_address = directed_rows[i].a0;
      tw.plane1_address = directed_rows[i].a1;
      tw.last = 1'b1;
      send_word(directed_rows[i].mode, directed_rows[i].line, directed_rows[i].col,
                directed_rows[i].p0, directed_rows[i].p1, directed_rows[i].typed, tw);
    end
    drain_block();

    // Random phases: low extremes, high extremes, then random settings.
    for (int phase = 0; phase < NumPhases; phase++) begin
      pal = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      case (phase)
        0: program_display({4{8'h00}}, 1'b0, 1'b0, 1'b0, 8'h00);
        1: program_display(pal, 1'b1, 1'b1, 1'b1, 8'hFF);
        default: program_display(pal, 1'($urandom), 1'($urandom), 1'($urandom),
                                 8'($urandom));
      endcase
      counted = 0;
      item    = 0;
      while (counted < WordsPerPhase) begin
        if (item % 12 == 0) begin
          tx_quiet = ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        item++;
        pick = $urandom_range(0, 99);
        col  = 6'($urandom_range(0, bvpg_pkg::Columns - 1));
        if (pick < 40) begin
          mode = bvpg_pkg::ModeAddr;
          counted++;
        end else if (pick < 86) begin
          mode = bvpg_pkg::ModePixel;
          counted++;
        end else if (pick < 92) begin
          mode = bvpg_pkg::ModeFrameEnd;
          counted++;
        end else if (pick < 95) begin
          mode = bvpg_pkg::ModeUnused;
        end else begin
          // Column past the visible area, no result.
          mode = pick[0] ? bvpg_pkg::ModeAddr : bvpg_pkg::ModePixel;
          col  = 6'($urandom_range(bvpg_pkg::Columns, 63));
        end
        send_word(mode, 8'($urandom), col, 8'($urandom), 8'($urandom), 1'b0, '0);
      end
      drain_block();
    end

    $display("Sent %0d input words (directed table and %0d register settings).",
             words_sent, NumPhases);
    $display("Checked %0d result words, %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
